@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl; they expect clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define ASSERT_HOLDS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_HOLDS(lbl, expr)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/lfpr_pkg.sv @@
package lfpr_pkg;

    // frame geometry
    localparam int MAX_FRAME_BYTES = 64;
    localparam int CNT_W           = 7;
    localparam int ADDR_W          = $clog2(MAX_FRAME_BYTES);
    localparam int LEN_INDEX       = 3;
    localparam int CHECK_INDEX     = 4;
    localparam int FRAME_OVERHEAD  = 2;
    localparam int LEN_LIMIT       = MAX_FRAME_BYTES - FRAME_OVERHEAD;

    // framing bytes
    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam logic [7:0] END_BYTE   = 8'h55;

    // receiver states
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_HEADER = 4'b0010,
        S_BODY   = 4'b0100,
        S_REPLAY = 4'b1000
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic restart;   // store at address zero, old count dropped
        logic store;     // write rx_byte and bump the count
        logic abandon;   // count back to zero
        logic rd_start;  // rewind the replay pointer
        logic rd_en;     // read next frame byte into the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cnt_ovf;
        logic hdr_last;
        logic len_match;
        logic len_big;
        logic is_start;
        logic is_end;
        logic is_zero;
        logic rd_last;
    } sts_t;

endpackage

@@ rtl/lfpr_datapath.sv @@
`include "assert_macros.svh"

module lfpr_datapath
    import lfpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output sts_t       sts,
    input  logic [7:0] rx_byte,
    output logic [7:0] frame_byte,
    output logic       frame_last
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_eff;
    logic [CNT_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] rd_idx_next;
    logic [7:0]       len_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic             wr_ok;
    logic [7:0]       frame_mem [MAX_FRAME_BYTES];

    // count seen by this byte: a restart drops an overflowed count
    assign count_eff = cmd.restart ? '0 : count_reg;

    // only the first MAX_FRAME_BYTES entries can ever be replayed
    assign wr_ok = (count_eff < CNT_W'(MAX_FRAME_BYTES));

    // status flags
    always_comb
    begin
        sts.cnt_ovf   = (count_reg > CNT_W'(MAX_FRAME_BYTES));
        sts.hdr_last  = (count_reg == CNT_W'(CHECK_INDEX));
        sts.len_match = ((9'(count_reg) + 9'd1) == (9'(len_reg) + 9'(FRAME_OVERHEAD)));
        sts.len_big   = (len_reg > 8'(LEN_LIMIT));
        sts.is_start  = (rx_byte == START_BYTE);
        sts.is_end    = (rx_byte == END_BYTE);
        sts.is_zero   = (rx_byte == 8'd0);
        sts.rd_last   = ((rd_idx_reg + CNT_W'(1)) == count_reg);
    end

    // byte counter and replay pointer
    always_comb
    begin
        count_next = count_reg;
        if (cmd.abandon)
        begin
            count_next = '0;
        end
        else if (cmd.store)
        begin
            count_next = count_eff + CNT_W'(1);
        end
        else if (cmd.restart)
        begin
            count_next = '0;
        end

        rd_idx_next = rd_idx_reg;
        if (cmd.rd_start)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.rd_en)
        begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    // length byte kept aside for the header limit check and the end check
    always_ff @(posedge clk)
    begin
        if (cmd.store && (count_eff == CNT_W'(LEN_INDEX)))
        begin
            len_reg <= rx_byte;
        end
    end

    // frame buffer with registered read, read data is the output register
    always_ff @(posedge clk)
    begin
        if (cmd.store && wr_ok)
        begin
            frame_mem[count_eff[ADDR_W-1:0]] <= rx_byte;
        end
        if (cmd.rd_en)
        begin
            byte_reg <= frame_mem[rd_idx_reg[ADDR_W-1:0]];
            last_reg <= sts.rd_last;
        end
    end

    assign frame_byte = byte_reg;
    assign frame_last = last_reg;

    `ASSERT_HOLDS(a_count_bound, count_reg <= CNT_W'(MAX_FRAME_BYTES + 1))
    `ASSERT_HOLDS(a_rd_in_frame, !cmd.rd_en || (rd_idx_reg < count_reg))
    `ASSERT_NEXT(a_replay_done_clears, cmd.rd_en && sts.rd_last, count_reg == '0)

endmodule

@@ rtl/lfpr_ctrl.sv @@
`include "assert_macros.svh"

module lfpr_ctrl
    import lfpr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    // no new bytes while a frame is being replayed
    assign in_stall = (state_reg == S_REPLAY);
    assign accept   = in_valid && !in_stall;

    // phase sequencing
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE, S_HEADER, S_BODY:
            begin
                if (accept)
                begin
                    if ((state_reg == S_IDLE) || sts.cnt_ovf)
                    begin
                        // hunt for the start byte
                        cmd.restart = 1'b1;
                        if (sts.is_start)
                        begin
                            cmd.store  = 1'b1;
                            state_next = S_HEADER;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else if (state_reg == S_HEADER)
                    begin
                        cmd.store = 1'b1;
                        if (sts.hdr_last)
                        begin
                            if (sts.is_zero || sts.len_big)
                            begin
                                cmd.abandon = 1'b1;
                                state_next  = S_IDLE;
                            end
                            else
                            begin
                                state_next = S_BODY;
                            end
                        end
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                        if (sts.is_end && sts.len_match)
                        begin
                            cmd.rd_start = 1'b1;
                            state_next   = S_REPLAY;
                        end
                    end
                end
            end
            S_REPLAY:
            begin
                // one frame byte per cycle while the output is free
                cmd.rd_en = !out_valid_reg || !out_stall;
                if (cmd.rd_en && sts.rd_last)
                begin
                    cmd.abandon = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                cmd.abandon = 1'b1;
                state_next  = S_IDLE;
            end
        endcase
    end

    // output valid follows the read data register
    always_comb
    begin
        if (cmd.rd_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `ASSERT_HOLDS(a_no_store_in_replay, !(cmd.store && cmd.rd_en))
    `ASSERT_NEXT(a_replay_starts, cmd.rd_start, state_reg == S_REPLAY)
    `ASSERT_NEXT(a_read_shows, cmd.rd_en, out_valid_reg)

endmodule

@@ rtl/length_framed_packet_receiver_top.sv @@
// the end byte moves the phase to replay, which registers the first frame byte
// throughput: 1 received byte per cycle while hunting or collecting a frame
// a completed frame of n bytes replays from the frame buffer read port at 1 byte
// per cycle while the output is free; input stalls until the last byte is read
// reset: phase idle and byte count zero; frame buffer contents are not cleared
module length_framed_packet_receiver_top
    import lfpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] frame_byte,
    output logic       frame_last
);

    cmd_t cmd;
    sts_t sts;

    // phase control and output handshake
    lfpr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // counter, length, frame buffer and output data
    lfpr_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .rx_byte    (rx_byte),
        .frame_byte (frame_byte),
        .frame_last (frame_last)
    );

endmodule

@@ verif/tb_length_framed_packet_receiver_top.sv @@
`timescale 1ns / 100ps

module tb_length_framed_packet_receiver_top
    import lfpr_pkg::*;
;

    localparam int HDR_BYTES    = 5;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 8;

    // one byte of a replayed frame
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_rsp_t;

    // shapes of byte sequences offered to the receiver
    typedef enum int {
        GOOD_FRAME,
        MAX_FRAME,
        ZERO_CHECK,
        OVERSIZE_LEN,
        SHORT_LEN,
        BAD_END,
        LINE_NOISE
    } frame_kind_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] frame_byte;
    logic       frame_last;

    // receiver copy kept by the testbench
    state_t     rx_state  = S_IDLE;
    logic [6:0] rcv_count = 7'd0;
    logic [7:0] frame_buf [0:MAX_FRAME_BYTES];

    frame_rsp_t pending_frame_bytes[$];
    frame_rsp_t oldest_byte;
    int         errors        = 0;
    int         quiet_cycles  = 0;
    int         send_idle_pct = 0;
    int         stall_pct     = 0;

    length_framed_packet_receiver_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .frame_last (frame_last)
    );

    // clock
    always #1 clk = ~clk;

    // random output back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // store one received byte and bump the count
    function automatic void keep_byte(input logic [7:0] b);
        if (rcv_count < MAX_FRAME_BYTES + 1)
            frame_buf[rcv_count] = b;
        rcv_count = rcv_count + 7'd1;
    endfunction

    // advance the deframer by one byte and queue any completed frame
    function automatic void deframe_byte(input logic [7:0] b);
        int k;
        if (rcv_count > MAX_FRAME_BYTES)
        begin
            rx_state  = S_IDLE;
            rcv_count = 7'd0;
        end
        case (rx_state)
            S_IDLE:
            begin
                if (b == START_BYTE)
                begin
                    rx_state = S_HEADER;
                    keep_byte(b);
                end
            end
            S_HEADER:
            begin
                keep_byte(b);
                if (rcv_count >= HDR_BYTES)
                begin
                    if (frame_buf[CHECK_INDEX] == 8'h00 || frame_buf[LEN_INDEX] > LEN_LIMIT)
                    begin
                        rx_state  = S_IDLE;
                        rcv_count = 7'd0;
                    end
                    else
                        rx_state = S_BODY;
                end
            end
            S_BODY:
            begin
                keep_byte(b);
                if (b == END_BYTE && rcv_count == frame_buf[LEN_INDEX] + FRAME_OVERHEAD)
                begin
                    for (k = 0; k < rcv_count && k < MAX_FRAME_BYTES; k++)
                        pending_frame_bytes.push_back({frame_buf[k], 1'(k + 1 == rcv_count)});
                    rx_state  = S_IDLE;
                    rcv_count = 7'd0;
                end
            end
            default:
            begin
                rx_state  = S_IDLE;
                rcv_count = 7'd0;
            end
        endcase
    endfunction

    // offer one byte, hold it until taken, then predict
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        deframe_byte(b);
    endtask

    // hold off the sender until every predicted frame byte has come out
    task automatic wait_for_frames();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_frame_bytes.size() != 0)
            @(posedge clk);
    endtask

    // one sequence of the given shape, reports how many bytes it took
    task automatic send_frame(input frame_kind_t kind, output int sent);
        logic [7:0] len;
        logic [7:0] b;
        int         total;
        int         i;
        if (kind == LINE_NOISE)
        begin
            total = $urandom_range(1, 4);
            for (i = 0; i < total; i++)
                send_byte(8'($urandom));
            sent = total;
            return;
        end
        case (kind)
            GOOD_FRAME:   len = ($urandom_range(9) == 0) ? 8'($urandom_range(13, LEN_LIMIT))
                                                         : 8'($urandom_range(4, 12));
            MAX_FRAME:    len = 8'(LEN_LIMIT);
            ZERO_CHECK:   len = 8'($urandom_range(4, LEN_LIMIT));
            OVERSIZE_LEN: len = 8'($urandom_range(LEN_LIMIT + 1, 255));
            SHORT_LEN:    len = 8'($urandom_range(0, 3));
            default:      len = 8'($urandom_range(4, 12));
        endcase
        send_byte(START_BYTE);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        send_byte(len);
        send_byte((kind == ZERO_CHECK) ? 8'h00 : 8'($urandom_range(1, 255)));
        sent = HDR_BYTES;
        if (kind == ZERO_CHECK || kind == OVERSIZE_LEN)
            return;
        // frames that never close run on until the count overflows
        total = (kind == SHORT_LEN || kind == BAD_END) ? MAX_FRAME_BYTES + 1
                                                       : len + FRAME_OVERHEAD;
        for (i = HDR_BYTES; i < total; i++)
        begin
            if (i == total - 1 && (kind == GOOD_FRAME || kind == MAX_FRAME))
                b = END_BYTE;
            else if ($urandom_range(7) == 0)
                b = $urandom_range(1) ? END_BYTE : START_BYTE;
            else
                b = 8'($urandom);
            if (kind == BAD_END && i == len + FRAME_OVERHEAD - 1 && b == END_BYTE)
                b = START_BYTE;
            send_byte(b);
        end
        sent = total;
    endtask

    // bytes while hunting are dropped
    task automatic test_idle_noise();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(END_BYTE);
        send_byte(8'h7F);
    endtask

    // shortest legal frame with extreme header bytes
    task automatic test_shortest_frame();
        send_byte(START_BYTE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h04);
        send_byte(8'hFF);
        send_byte(END_BYTE);
    endtask

    // zero check byte drops the header, trailing end byte ignored
    task automatic test_zero_check();
        send_byte(START_BYTE);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h05);
        send_byte(8'h00);
        send_byte(END_BYTE);
    endtask

    // length one above the limit is dropped
    task automatic test_oversize_length();
        send_byte(START_BYTE);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'(LEN_LIMIT + 1));
        send_byte(8'h01);
    endtask

    // start and end bytes inside the header are plain data
    task automatic test_framing_bytes_in_header();
        send_byte(START_BYTE);
        send_byte(START_BYTE);
        send_byte(END_BYTE);
        send_byte(8'h04);
        send_byte(8'h01);
        send_byte(END_BYTE);
    endtask

    // mostly well-formed frames with random content, some broken ones and noise
    task automatic test_random_frames(input int idle_p, input int stall_p,
                                      input int item_goal, input bit with_extremes);
        int          sent;
        int          done;
        int          pick;
        frame_kind_t kind;
        send_idle_pct = idle_p;
        stall_pct     = stall_p;
        done          = 0;
        if (with_extremes)
        begin
            send_frame(MAX_FRAME, sent);
            done += sent;
            send_frame(SHORT_LEN, sent);
            done += sent;
        end
        while (done < item_goal)
        begin
            pick = $urandom_range(99);
            if (pick < 58)
                kind = GOOD_FRAME;
            else if (pick < 60)
                kind = MAX_FRAME;
            else if (pick < 68)
                kind = ZERO_CHECK;
            else if (pick < 76)
                kind = OVERSIZE_LEN;
            else if (pick < 80)
                kind = SHORT_LEN;
            else if (pick < 84)
                kind = BAD_END;
            else
                kind = LINE_NOISE;
            send_frame(kind, sent);
            done += sent;
        end
        wait_for_frames();
    endtask

    // compare each replayed byte with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_frame_bytes.size() == 0)
            begin
                $display("%0t: unexpected frame byte: expected none, actual %h last %b",
                         $time, frame_byte, frame_last);
                errors++;
            end
            else
            begin
                oldest_byte = pending_frame_bytes.pop_front();
                if (frame_byte !== oldest_byte.data)
                begin
                    $display("%0t: frame_byte mismatch: expected %h, actual %h",
                             $time, oldest_byte.data, frame_byte);
                    errors++;
                end
                if (frame_last !== oldest_byte.last)
                begin
                    $display("%0t: frame_last mismatch: expected %b, actual %b",
                             $time, oldest_byte.last, frame_last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles where no request moves on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
            $display("** length_framed_packet_receiver_top: FAILED **");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_noise();
        test_shortest_frame();
        test_zero_check();
        test_oversize_length();
        test_framing_bytes_in_header();
        wait_for_frames();

        test_random_frames(0, 0, 120, 1'b1);
        test_random_frames(60, 0, 120, 1'b0);
        test_random_frames(0, 60, 120, 1'b0);
        test_random_frames(9, 9, 120, 1'b1);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending_frame_bytes.size() == 0)
            $display("** length_framed_packet_receiver_top: PASSED **");
        else
            $display("** length_framed_packet_receiver_top: FAILED **");
        $finish;
    end

endmodule
